// ----- sv/lc3s_pkg.sv -----
// ----------------------------------------------------------------------------
// lc3s_pkg
// Shared types, codes and helpers for the LC-3 instruction step block.
// ----------------------------------------------------------------------------
package lc3s_pkg;

  localparam int MemWordsDefault = 65536;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_EXEC    = 2'd0,
    FUNC_MEM_WR  = 2'd1,
    FUNC_REG_WR  = 2'd2,
    FUNC_SET_PC  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_HALTED  = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  // opcodes
  typedef enum logic [3:0] {
    OP_BR   = 4'h0, OP_ADD  = 4'h1, OP_LD   = 4'h2, OP_ST   = 4'h3,
    OP_JSR  = 4'h4, OP_AND  = 4'h5, OP_LDR  = 4'h6, OP_STR  = 4'h7,
    OP_RTI  = 4'h8, OP_NOT  = 4'h9, OP_LDI  = 4'ha, OP_STI  = 4'hb,
    OP_JMP  = 4'hc, OP_RES  = 4'hd, OP_LEA  = 4'he, OP_TRAP = 4'hf
  } opcode_t;

  // trap vectors serviced in place
  localparam logic [7:0] VEC_GETC = 8'h20;
  localparam logic [7:0] VEC_OUT  = 8'h21;
  localparam logic [7:0] VEC_IN   = 8'h23;
  localparam logic [7:0] VEC_HALT = 8'h25;

  // condition codes: bit2 N, bit1 Z, bit0 P
  localparam logic [2:0] CC_N = 3'b100;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_P = 3'b001;

  // controller commands to the datapath
  typedef struct packed {
    logic clear;   // memory clearing pass
    logic latch;   // take the input item
    logic cmd;     // do write/set-PC item or execute checks
    logic fetch;   // read instruction
    logic decode;  // load IR, bump PC
    logic exec;    // execute or form effective address
    logic mema;    // first memory access
    logic ptr;     // take pointer for indirect access
    logic memb;    // indirect access
    logic memd;    // load data writeback
    logic out_load;
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic clear_done;
    logic go_fetch;
    logic is_ld;   // LD, LDR
    logic is_ldi;
    logic is_st;   // ST, STR
    logic is_sti;
  } dp_stat_t;

  function automatic logic [2:0] cc_of(input logic [15:0] w);
    logic [2:0] c;
    if (w[15]) c = CC_N;
    else if (w == 16'h0000) c = CC_Z;
    else c = CC_P;
    return c;
  endfunction

endpackage

// ----- sv/lc3s_ctrl.sv -----
// ----------------------------------------------------------------------------
// lc3s_ctrl
// Sequencer: clearing pass, item intake, instruction phases, result handoff.
// ----------------------------------------------------------------------------
module lc3s_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  lc3s_pkg::dp_stat_t stat,
  output lc3s_pkg::dp_cmd_t  cmd
);
  import lc3s_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_CMD    = 11'b00000000100,
    S_FETCH  = 11'b00000001000,
    S_DECODE = 11'b00000010000,
    S_EXEC   = 11'b00000100000,
    S_MEMA   = 11'b00001000000,
    S_PTR    = 11'b00010000000,
    S_MEMB   = 11'b00100000000,
    S_MEMD   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_CLEAR);
    cmd.latch    = (state == S_IDLE) && s_tvalid;
    cmd.cmd      = (state == S_CMD);
    cmd.fetch    = (state == S_FETCH);
    cmd.decode   = (state == S_DECODE);
    cmd.exec     = (state == S_EXEC);
    cmd.mema     = (state == S_MEMA);
    cmd.ptr      = (state == S_PTR);
    cmd.memb     = (state == S_MEMB);
    cmd.memd     = (state == S_MEMD);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = S_CMD;
      S_CMD:    state_next = stat.go_fetch ? S_FETCH : S_DONE;
      S_FETCH:  state_next = S_DECODE;
      S_DECODE: state_next = S_EXEC;
      S_EXEC: begin
        if (stat.is_ld || stat.is_ldi || stat.is_st || stat.is_sti) state_next = S_MEMA;
        else state_next = S_DONE;
      end
      S_MEMA: begin
        if (stat.is_ld) state_next = S_MEMD;
        else if (stat.is_ldi || stat.is_sti) state_next = S_PTR;
        else state_next = S_DONE;
      end
      S_PTR:    state_next = S_MEMB;
      S_MEMB:   state_next = stat.is_ldi ? S_MEMD : S_DONE;
      S_MEMD:   state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- sv/lc3s_dpath.sv -----
// ----------------------------------------------------------------------------
// lc3s_dpath
// Architectural state, word memory, address reduction and result register.
// ----------------------------------------------------------------------------
module lc3s_dpath #(
  parameter int MEM_WORDS = lc3s_pkg::MemWordsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [39:0]        s_tdata,  // target_index[15:0], write_value, in_char
  input  logic [1:0]         s_tuser,  // func
  output logic [47:0]        m_tdata,  // pc_now, instr_word, cond_codes, is_running,
                                       // char_valid, char_out, status
  input  lc3s_pkg::dp_cmd_t  cmd,
  output lc3s_pkg::dp_stat_t stat
);
  import lc3s_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  // reciprocal for exact 16-bit quotient by MEM_WORDS
  localparam logic [40:0] RECIP =
    41'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;

  logic [15:0] regs [8];
  logic [15:0] pc, ir;
  logic [2:0]  cc;
  logic        running;
  logic [AW-1:0] clr_cnt;

  logic [1:0]  in_func;
  logic [15:0] in_idx, in_val;
  logic [7:0]  in_ch;

  logic [15:0] ea;
  logic [7:0]  quot;
  logic [1:0]  status;
  logic        cvalid;
  logic [7:0]  cout;

  logic [3:0]  op;
  logic [2:0]  dr, sr1;
  logic [15:0] sx9, sx6, sx11, sx5, alu_b, ea_comb, mul_src;
  logic [40:0] prod;
  logic [16:0] qm, red_full;
  logic [AW-1:0] red_addr;
  logic        pc_ok, idx_ok;

  assign op  = ir[15:12];
  assign dr  = ir[11:9];
  assign sr1 = ir[8:6];
  assign sx9  = {{7{ir[8]}}, ir[8:0]};
  assign sx6  = {{10{ir[5]}}, ir[5:0]};
  assign sx11 = {{5{ir[10]}}, ir[10:0]};
  assign sx5  = {{11{ir[4]}}, ir[4:0]};
  assign alu_b = ir[5] ? sx5 : regs[ir[2:0]];
  assign ea_comb = (op == OP_LDR || op == OP_STR) ? regs[sr1] + sx6 : pc + sx9;

  // address modulo MEM_WORDS: quotient registered, remainder next cycle
  assign mul_src  = cmd.ptr ? rdata : ea_comb;
  assign prod     = 41'(mul_src) * RECIP;
  assign qm       = 17'(quot) * 17'(MEM_WORDS);
  assign red_full = {1'b0, ea} - qm;
  assign red_addr = red_full[AW-1:0];

  assign pc_ok  = {1'b0, pc} < 17'(MEM_WORDS);
  assign idx_ok = {1'b0, in_idx} < 17'(MEM_WORDS);

  // status to controller
  assign stat.clear_done = (clr_cnt == AW'(MEM_WORDS - 1));
  assign stat.go_fetch   = (in_func == FUNC_EXEC) && running && pc_ok;
  assign stat.is_ld      = (op == OP_LD) || (op == OP_LDR);
  assign stat.is_ldi     = (op == OP_LDI);
  assign stat.is_st      = (op == OP_ST) || (op == OP_STR);
  assign stat.is_sti     = (op == OP_STI);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = red_addr;
    mem_wdata = regs[dr];
    priority if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt;
      mem_wdata = 16'h0000;
    end else if (cmd.cmd) begin
      mem_we    = (in_func == FUNC_MEM_WR) && idx_ok;
      mem_addr  = in_idx[AW-1:0];
      mem_wdata = in_val;
    end else if (cmd.fetch) begin
      mem_addr  = pc[AW-1:0];
    end else if (cmd.mema) begin
      mem_we    = stat.is_st;
    end else if (cmd.memb) begin
      mem_we    = stat.is_sti;
    end else begin
      mem_we    = 1'b0;
    end
  end

  // word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_func <= s_tuser;
      in_idx  <= s_tdata[15:0];
      in_val  <= s_tdata[31:16];
      in_ch   <= s_tdata[39:32];
    end
    if (cmd.exec || cmd.ptr) begin
      ea   <= mul_src;
      quot <= prod[39:32];
    end
    if (cmd.out_load)
      m_tdata <= {1'b0, status, cout, cvalid, running, cc, ir, pc};
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= 16'h0000;
      pc      <= 16'h0000;
      ir      <= 16'h0000;
      cc      <= CC_Z;
      running <= 1'b1;
      status  <= ST_DONE;
      cvalid  <= 1'b0;
      cout    <= 8'h00;
    end else begin
      if (cmd.latch) begin
        status <= ST_DONE;
        cvalid <= 1'b0;
        cout   <= 8'h00;
      end
      // write, set-PC and execute pre-checks
      if (cmd.cmd) begin
        unique case (in_func)
          FUNC_MEM_WR: if (idx_ok) running <= 1'b1; else status <= ST_BAD;
          FUNC_REG_WR: begin
            if (in_idx < 16'd8) begin
              regs[in_idx[2:0]] <= in_val;
              running <= 1'b1;
            end else status <= ST_BAD;
          end
          FUNC_SET_PC: if (idx_ok) pc <= in_idx; else status <= ST_BAD;
          default: begin
            if (!running) status <= ST_IGNORED;
            else if (!pc_ok) begin
              running <= 1'b0;
              status  <= ST_HALTED;
            end
          end
        endcase
      end
      if (cmd.decode) begin
        ir <= rdata;
        pc <= pc + 16'd1;
      end
      // register-only instructions
      if (cmd.exec) begin
        unique case (op)
          OP_BR: if ((dr & cc) != 3'b000) pc <= pc + sx9;
          OP_ADD: begin
            regs[dr] <= regs[sr1] + alu_b;
            cc       <= cc_of(regs[sr1] + alu_b);
          end
          OP_AND: begin
            regs[dr] <= regs[sr1] & alu_b;
            cc       <= cc_of(regs[sr1] & alu_b);
          end
          OP_NOT: begin
            regs[dr] <= ~regs[sr1];
            cc       <= cc_of(~regs[sr1]);
          end
          OP_LEA: begin
            regs[dr] <= pc + sx9;
            cc       <= cc_of(pc + sx9);
          end
          OP_JMP: pc <= regs[sr1];
          OP_JSR: begin
            regs[7] <= pc;
            pc      <= ir[11] ? pc + sx11 : regs[sr1];
          end
          OP_TRAP: begin
            regs[7] <= pc;
            if (ir[7:0] == VEC_GETC || ir[7:0] == VEC_IN) regs[0] <= {8'h00, in_ch};
            else if (ir[7:0] == VEC_OUT) begin
              cvalid <= 1'b1;
              cout   <= regs[0][7:0];
            end else if (ir[7:0] == VEC_HALT) begin
              running <= 1'b0;
              status  <= ST_HALTED;
            end
          end
          OP_RTI, OP_RES: begin
            running <= 1'b0;
            status  <= ST_HALTED;
          end
          default: ; // memory ops continue in later phases
        endcase
      end
      // load writeback
      if (cmd.memd) begin
        regs[dr] <= rdata;
        cc       <= cc_of(rdata);
      end
    end
  end

endmodule

// ----- sv/lc3_instruction_step.sv -----
// ----------------------------------------------------------------------------
// lc3_instruction_step
// LC-3 processor stepped one item at a time, with its own word memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tuser: func; tdata: target_index, write_value, in_char
// m_*      out  tdata: pc_now, instr_word, cond_codes, is_running,
//               char_valid, char_out, status
//
// After reset the memory is zeroed one word a cycle, with s_tready low
// throughout. One item at a time on a single-port synchronous memory.
// Write/set-PC items and ignored executes pass intake, command and done.
// Instructions add fetch, decode and execute; LD/LDR add a memory access
// and writeback, ST/STR a memory access, LDI/STI a pointer step and second
// access (LDI then writeback). A stalled output holds the block in its final phase.
module lc3_instruction_step #(
  parameter int MEM_WORDS = lc3s_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [15:0] target_index, [31:16] write_value, [39:32] in_char
  input  logic [1:0]  s_tuser,  // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // [15:0] pc_now, [31:16] instr_word, [34:32] cond_codes,
                                // [35] is_running, [36] char_valid, [44:37] char_out,
                                // [46:45] status
);
  import lc3s_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lc3s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lc3s_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

// ----- sv/lc3s_checker.sv -----
// ----------------------------------------------------------------------------
// lc3s_checker
// Port-level checks for the LC-3 instruction step block.
// ----------------------------------------------------------------------------
module lc3s_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import lc3s_pkg::*;

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // one item at a time
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken back to back");

  // an ignored execute reports a halted machine
  a_ign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[46:45] == ST_IGNORED |-> !m_tdata[35])
    else $error("ignored item with machine running");

  // a halting item clears the running flag
  a_halt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[46:45] == ST_HALTED |-> !m_tdata[35])
    else $error("halt reported while running");

  // a character only comes with a completed item
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36] |-> m_tdata[46:45] == ST_DONE)
    else $error("character with non-done status");

endmodule

bind lc3_instruction_step lc3s_checker u_lc3s_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks lc3_instruction_step one item at a time. A directed table goes
// first: bad register numbers, address and PC wraparound, halt and restart,
// the trap services and the halting opcodes. Random short programs follow:
// each writes instruction words and registers, points the PC at them and
// steps through them. Every result is compared field by field with a
// predictor that runs in step with the items as they are accepted. Both
// handshake sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import lc3s_pkg::*;

  localparam int NumRandomItems = 500;

  // result fields in the order of the bits in m_tdata
  typedef struct packed {
    status_t     st;
    logic [7:0]  co;
    logic        cv;
    logic        run;
    logic [2:0]  cc;
    logic [15:0] ir;
    logic [15:0] pc;
  } step_result_t;

  typedef struct {
    func_t        func;
    logic [15:0]  idx;
    logic [15:0]  val;
    logic [7:0]   ch;
    bit           typed;
    step_result_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  // predictor state
  logic [15:0] mem_img [0:65535];
  logic [15:0] regs [0:7];
  logic [15:0] pc_q;
  logic [15:0] ir_q;
  logic [2:0]  cc_q;
  logic        run_q;

  step_result_t pending_q[$];
  table_row_t   rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int halts_seen = 0;
  int chars_seen = 0;
  bit no_gaps = 1'b0;

  lc3_instruction_step DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] sx(logic [15:0] v, int bits);
    logic [15:0] m;
    logic [15:0] x;
    m = (16'h1 << bits) - 16'h1;
    x = v & m;
    if (x[bits-1]) x = x | ~m;
    return x;
  endfunction

  function automatic void load_reg(logic [2:0] r, logic [15:0] w);
    regs[r] = w;
    if (w[15]) cc_q = CC_N;
    else if (w == 16'h0) cc_q = CC_Z;
    else cc_q = CC_P;
  endfunction

  // one instruction; memory covers the full address space so no wrap check
  function automatic status_t run_instr(logic [7:0] ch, ref logic cv, ref logic [7:0] co);
    logic [15:0] ir;
    logic [15:0] p;
    logic [15:0] tgt;
    logic [2:0]  dr;
    logic [2:0]  sr;
    logic [15:0] b;
    if (!run_q) return ST_IGNORED;
    ir = mem_img[pc_q];
    ir_q = ir;
    pc_q = pc_q + 16'h1;
    p = pc_q;
    dr = ir[11:9];
    sr = ir[8:6];
    case (opcode_t'(ir[15:12]))
      OP_BR: if (dr & cc_q) pc_q = p + sx(ir, 9);
      OP_ADD, OP_AND: begin
        b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
        load_reg(dr, (ir[15:12] == OP_ADD) ? regs[sr] + b : regs[sr] & b);
      end
      OP_LD:  load_reg(dr, mem_img[p + sx(ir, 9)]);
      OP_ST:  mem_img[p + sx(ir, 9)] = regs[dr];
      OP_JSR: begin
        tgt = ir[11] ? p + sx(ir, 11) : regs[sr];
        regs[7] = p;
        pc_q = tgt;
      end
      OP_LDR: load_reg(dr, mem_img[regs[sr] + sx(ir, 6)]);
      OP_STR: mem_img[regs[sr] + sx(ir, 6)] = regs[dr];
      OP_NOT: load_reg(dr, ~regs[sr]);
      OP_LDI: load_reg(dr, mem_img[mem_img[p + sx(ir, 9)]]);
      OP_STI: mem_img[mem_img[p + sx(ir, 9)]] = regs[dr];
      OP_JMP: pc_q = regs[sr];
      OP_LEA: load_reg(dr, p + sx(ir, 9));
      OP_TRAP: begin
        regs[7] = p;
        case (ir[7:0])
          VEC_GETC, VEC_IN: regs[0] = {8'h0, ch};
          VEC_OUT: begin
            cv = 1'b1;
            co = regs[0][7:0];
          end
          VEC_HALT: begin
            run_q = 1'b0;
            return ST_HALTED;
          end
          default: ;
        endcase
      end
      default: begin
        // RTI and the reserved opcode stop the machine
        run_q = 1'b0;
        return ST_HALTED;
      end
    endcase
    return ST_DONE;
  endfunction

  function automatic step_result_t predict_step(func_t f, logic [15:0] idx,
                                                logic [15:0] val, logic [7:0] ch);
    step_result_t r;
    logic cv;
    logic [7:0] co;
    cv = 1'b0;
    co = 8'h0;
    r.st = ST_DONE;
    case (f)
      FUNC_EXEC: r.st = run_instr(ch, cv, co);
      FUNC_MEM_WR: begin
        mem_img[idx] = val;
        run_q = 1'b1;
      end
      FUNC_REG_WR: begin
        if (idx < 16'd8) begin
          regs[idx[2:0]] = val;
          run_q = 1'b1;
        end else r.st = ST_BAD;
      end
      default: pc_q = idx;
    endcase
    r.pc = pc_q;
    r.ir = ir_q;
    r.cc = cc_q;
    r.run = run_q;
    r.cv = cv;
    r.co = co;
    return r;
  endfunction

  function automatic int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  // send one item and queue what it should produce
  task automatic send(func_t f, logic [15:0] idx, logic [15:0] val, logic [7:0] ch,
                      bit typed = 1'b0, step_result_t want = '0);
    step_result_t r;
    bit ok;
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {ch, val, idx};
    ok = 1'b0;
    while (!ok) begin
      @(posedge clk);
      ok = s_tready;
      @(negedge clk);
    end
    r = predict_step(f, idx, val, ch);
    pending_q.push_back(typed ? want : r);
    items_sent++;
    if (items_sent % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  function automatic step_result_t mk(logic [15:0] pc, logic [15:0] ir, logic [2:0] cc,
                                      logic run, status_t st);
    step_result_t r;
    r = '0;
    r.pc = pc;
    r.ir = ir;
    r.cc = cc;
    r.run = run;
    r.st = st;
    return r;
  endfunction

  function automatic void row(func_t f, logic [15:0] idx, logic [15:0] val, logic [7:0] ch,
                              bit typed = 1'b0, step_result_t want = '0);
    table_row_t t;
    t.func = f;
    t.idx = idx;
    t.val = val;
    t.ch = ch;
    t.typed = typed;
    t.want = want;
    rows.push_back(t);
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    // favor the serviced trap vectors
    if (w[15:12] == OP_TRAP && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: w[7:0] = VEC_GETC;
        1: w[7:0] = VEC_OUT;
        2: w[7:0] = VEC_IN;
        default: w[7:0] = VEC_HALT;
      endcase
    end
    // keep halts from dominating
    if ((w[15:12] == OP_RTI || w[15:12] == OP_RES) && $urandom_range(0, 2) != 0)
      w[15:12] = OP_ADD;
    return w;
  endfunction

  // result checker: sampled at the accepting edge
  always @(posedge clk) begin
    step_result_t got;
    step_result_t want;
    if (m_tvalid && m_tready) begin
      got = step_result_t'(m_tdata[46:0]);
      results_seen++;
      if (got.st == ST_HALTED) halts_seen++;
      if (got.cv) chars_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = pending_q.pop_front();
        if (got.pc != want.pc || got.ir != want.ir || got.cc != want.cc ||
            got.run != want.run || got.cv != want.cv || got.co != want.co ||
            got.st != want.st || m_tdata[47] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected pc=%h ir=%h cc=%b run=%b cv=%b co=%h st=%0d,",
                      " got pc=%h ir=%h cc=%b run=%b cv=%b co=%h st=%0d"},
                     results_seen, want.pc, want.ir, want.cc, want.run, want.cv, want.co,
                     want.st, got.pc, got.ir, got.cc, got.run, got.cv, got.co, got.st);
        end
      end
    end
  end

  // output stall pattern: a wait drawn at each accepted result
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) hold = pick_gap();
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("lc3_instruction_step test failed");
    $finish;
  end

  initial begin
    logic [15:0] base;
    int n;
    int wait_cyc;
    for (int i = 0; i < 65536; i++) mem_img[i] = 16'h0;
    for (int i = 0; i < 8; i++) regs[i] = 16'h0;
    pc_q = 16'h0;
    ir_q = 16'h0;
    cc_q = CC_Z;
    run_q = 1'b1;

    // directed table
    row(FUNC_REG_WR, 16'd8, 16'hffff, 8'h00, 1, mk(16'h0, 16'h0, CC_Z, 1, ST_BAD));
    row(FUNC_REG_WR, 16'hffff, 16'h0, 8'hff, 1, mk(16'h0, 16'h0, CC_Z, 1, ST_BAD));
    // zero word is BR with nzp clear: falls through
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00, 1, mk(16'h1, 16'h0, CC_Z, 1, ST_DONE));
    row(FUNC_MEM_WR, 16'hffff, {OP_TRAP, 4'h0, VEC_HALT}, 8'h00, 1,
        mk(16'h1, 16'h0, CC_Z, 1, ST_DONE));
    row(FUNC_SET_PC, 16'hffff, 16'h0, 8'h00, 1, mk(16'hffff, 16'h0, CC_Z, 1, ST_DONE));
    // halt at the top of memory, PC wraps to zero
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00, 1, mk(16'h0, 16'hf025, CC_Z, 0, ST_HALTED));
    row(FUNC_EXEC, 16'h0, 16'h0, 8'hff, 1, mk(16'h0, 16'hf025, CC_Z, 0, ST_IGNORED));
    // set PC while halted keeps the machine stopped
    row(FUNC_SET_PC, 16'h0, 16'hffff, 8'h00, 1, mk(16'h0, 16'hf025, CC_Z, 0, ST_DONE));
    row(FUNC_REG_WR, 16'd0, 16'h00c1, 8'h00);
    row(FUNC_MEM_WR, 16'd0, {OP_TRAP, 4'h0, VEC_OUT}, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00);
    row(FUNC_MEM_WR, 16'd1, {OP_TRAP, 4'h0, VEC_IN}, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'hff);
    row(FUNC_MEM_WR, 16'd2, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00);
    row(FUNC_MEM_WR, 16'd3, {OP_TRAP, 4'h0, VEC_GETC}, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00);
    row(FUNC_MEM_WR, 16'd4, {OP_RTI, 12'h0}, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00);
    row(FUNC_MEM_WR, 16'd5, {OP_RES, 12'hfff}, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00);
    row(FUNC_REG_WR, 16'd7, 16'hffff, 8'h00);
    row(FUNC_MEM_WR, 16'd6, {OP_JMP, 3'd0, 3'd7, 6'd0}, 8'h00);
    row(FUNC_SET_PC, 16'd6, 16'h0, 8'h00);
    row(FUNC_EXEC, 16'h0, 16'h0, 8'h00);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send(rows[i].func, rows[i].idx, rows[i].val, rows[i].ch, rows[i].typed, rows[i].want);

    // random programs: load words, set registers, point the PC, step
    while (items_sent < NumRandomItems + rows.size()) begin
      if ($urandom_range(0, 9) == 0) begin
        send(func_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          send(FUNC_MEM_WR, base + 16'(k), rand_instr(), 8'($urandom));
        repeat ($urandom_range(0, 2))
          send(FUNC_REG_WR, 16'($urandom_range(0, 9)), 16'($urandom), 8'($urandom));
        send(FUNC_SET_PC, base, 16'($urandom), 8'($urandom));
        repeat (n + $urandom_range(0, 2))
          send(FUNC_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    wait_cyc = 0;
    while (pending_q.size() != 0 && wait_cyc < 100000) begin
      @(negedge clk);
      wait_cyc++;
    end
    repeat (20) @(negedge clk);

    $display("%0d items sent, %0d results checked, %0d halts, %0d characters out",
             items_sent, results_seen, halts_seen, chars_seen);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("lc3_instruction_step test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("lc3_instruction_step test failed");
    end
    $finish;
  end

endmodule

// ----- lc3_instruction_step.f -----
sv/lc3s_pkg.sv
sv/lc3s_ctrl.sv
sv/lc3s_dpath.sv
sv/lc3_instruction_step.sv
sv/lc3s_checker.sv
tb/testbench.sv
